// ===== design/ascii_setpoint_command_parser_macros.svh =====
// ----------------------------------------------------------------------------
// ASCII setpoint command parser assertion macros
// Shared property shapes for the port checker. Each macro expects signals
// named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASCII_SETPOINT_COMMAND_PARSER_MACROS_SVH
`define ASCII_SETPOINT_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define ASCP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive during reset.
`define ASCP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define ASCP_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== design/ascp_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCP package
// Types, constants and reply text for the ASCII setpoint command parser.
// ----------------------------------------------------------------------------
package ascp_pkg;

  // Default number of decimal digits accepted after "SET ".
  localparam int unsigned MAX_DIGITS_DEF = 4;

  // Numeric limits of the SET command.
  localparam int unsigned SP_MAX    = 1023;
  localparam int unsigned VAL_LIMIT = 9999;

  // Character codes.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Command words as they sit in the first bytes of a frame.
  localparam logic [31:0] TXT_SET = "SET ";
  localparam logic [39:0] TXT_INC = {"INC", CH_CR, CH_LF};
  localparam logic [39:0] TXT_DEC = {"DEC", CH_CR, CH_LF};
  localparam logic [39:0] TXT_REQ = {"REQ", CH_CR, CH_LF};
  localparam logic [39:0] TXT_MON = {"MON", CH_CR, CH_LF};

  // Reply text store: all fixed replies back to back.
  localparam int unsigned MSG_LEN = 34;
  localparam int unsigned PTR_W   = $clog2(MSG_LEN);
  localparam logic [7:0] MSG_ROM [MSG_LEN] = '{
    "U", "N", "K", "N", "O", "W", "N", " ", "C", "O", "M", "M", "A", "N", "D",
    CH_CR, CH_LF,
    "O", "U", "T", " ", "O", "F", " ", "R", "A", "N", "G", CH_CR, CH_LF,
    "m", "m", CH_CR, CH_LF
  };

  // Start and end positions of each reply in the text store.
  localparam logic [PTR_W-1:0] MSG_UNK_FIRST  = PTR_W'(0);
  localparam logic [PTR_W-1:0] MSG_UNK_LAST   = PTR_W'(16);
  localparam logic [PTR_W-1:0] MSG_RANG_FIRST = PTR_W'(17);
  localparam logic [PTR_W-1:0] MSG_RANG_LAST  = PTR_W'(29);
  localparam logic [PTR_W-1:0] MSG_MM_FIRST   = PTR_W'(30);
  localparam logic [PTR_W-1:0] MSG_MM_LAST    = PTR_W'(33);
  localparam logic [PTR_W-1:0] MSG_CRLF_FIRST = PTR_W'(32);
  localparam logic [PTR_W-1:0] MSG_CRLF_LAST  = PTR_W'(33);

  // Powers of ten for the decimal conversion, lowest first.
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned POW_N    = 5;
  localparam int unsigned POW_IDX_W = $clog2(POW_N);
  localparam logic [NUM_W-1:0] POW10 [POW_N] = '{
    16'd1, 16'd10, 16'd100, 16'd1000, 16'd10000
  };

  // Input and result payloads.
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] actual_value;
  } item_t;

  typedef struct packed {
    logic [7:0] response_byte;
    logic       last_of_reply;
    logic [9:0] setpoint;
  } reply_t;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TEXT,
    ST_NUM
  } state_t;

  // Decimal conversion unit states.
  typedef enum logic [1:0] {
    DG_IDLE,
    DG_RUN,
    DG_HOLD
  } dig_state_t;

  // Control from the sequencer to the conversion unit.
  typedef struct packed {
    logic start;
    logic take;
  } dig_req_t;

  // Status from the conversion unit to the sequencer.
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
    logic       last_digit;
  } dig_rsp_t;

endpackage

// ===== design/ascp_digit_unit.sv =====
// ----------------------------------------------------------------------------
// ASCP decimal digit unit
// Converts a 16-bit value to decimal digits, most significant first, with
// leading zeros suppressed. One shared subtract and compare is applied per
// cycle against a power of ten; each finished digit is held until taken.
// ----------------------------------------------------------------------------
module ascp_digit_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  ascp_pkg::dig_req_t             req,
  input  logic [ascp_pkg::NUM_W-1:0]     value,
  output ascp_pkg::dig_rsp_t             rsp
);

  ascp_pkg::dig_state_t state;
  ascp_pkg::dig_state_t state_next;

  logic [ascp_pkg::NUM_W-1:0]     rem;
  logic [ascp_pkg::POW_IDX_W-1:0] idx;
  logic [3:0]                     digit;
  logic                           started;

  logic [ascp_pkg::NUM_W:0] diff;
  logic                     fits;
  logic                     emit;

  // Shared subtractor: does the remainder still hold the current power?
  assign diff = {1'b0, rem} - {1'b0, ascp_pkg::POW10[idx]};
  assign fits = !diff[ascp_pkg::NUM_W];

  // A digit is shown once a nonzero digit appeared, or for the units place.
  assign emit = (digit != 4'd0) || started || (idx == '0);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ascp_pkg::DG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and status.
  always_comb begin
    state_next     = state;
    rsp.valid      = 1'b0;
    rsp.digit      = digit;
    rsp.last_digit = (idx == '0);
    unique case (state)
      ascp_pkg::DG_IDLE: begin
        if (req.start) begin
          state_next = ascp_pkg::DG_RUN;
        end
      end
      ascp_pkg::DG_RUN: begin
        if (!fits && emit) begin
          state_next = ascp_pkg::DG_HOLD;
        end
      end
      ascp_pkg::DG_HOLD: begin
        rsp.valid = 1'b1;
        if (req.take) begin
          state_next = (idx == '0) ? ascp_pkg::DG_IDLE : ascp_pkg::DG_RUN;
        end
      end
      default: begin
        state_next = ascp_pkg::DG_IDLE;
      end
    endcase
  end

  // Conversion datapath.
  always_ff @(posedge clk) begin
    if (state == ascp_pkg::DG_IDLE && req.start) begin
      rem     <= value;
      idx     <= ascp_pkg::POW_IDX_W'(ascp_pkg::POW_N - 1);
      digit   <= 4'd0;
      started <= 1'b0;
    end else if (state == ascp_pkg::DG_RUN) begin
      if (fits) begin
        rem   <= diff[ascp_pkg::NUM_W-1:0];
        digit <= digit + 4'd1;
      end else if (!emit) begin
        idx <= idx - 1'b1;
      end
    end else if (state == ascp_pkg::DG_HOLD && req.take) begin
      started <= 1'b1;
      digit   <= 4'd0;
      if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

endmodule

// ===== design/ascii_setpoint_command_parser.sv =====
// ----------------------------------------------------------------------------
// ASCII setpoint command parser
// Bytes enter on the item channel (rx_byte with actual_value), one transaction
// per byte; reply bytes leave on the reply channel, one transaction per byte,
// with last_of_reply marking the final byte and setpoint the value after the
// frame's command. A frame ends at CR followed by LF. Commands: SET n, INC,
// DEC, REQ and MON; anything else answers UNKNOWN COMMAND.
// Mid-frame bytes are accepted without a stall and give no reply.
// After the closing LF the block passes through a decode state. Fixed text
// replies then follow at one byte per cycle while the receiver keeps up.
// Decimal replies come from a shared subtract-and-compare unit that builds
// each digit by subtracting a power of ten and skips leading zero places.
// item_ready stays low from the closing LF until the last reply byte is in
// the output register; the next byte may be taken while that byte waits.
// A stalled receiver holds the output register and the sequencer waits.
// Reset (rst, synchronous) clears the setpoint, the frame state and the
// output valid flag.
// ----------------------------------------------------------------------------
module ascii_setpoint_command_parser #(
  parameter int unsigned MAX_DIGITS = ascp_pkg::MAX_DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ascp_pkg::item_t item,
  output logic            reply_valid,
  input  logic            reply_ready,
  output ascp_pkg::reply_t reply
);

  localparam int unsigned ACC_W = $clog2(10 ** MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CMP_W = (ACC_W > ascp_pkg::NUM_W) ? ACC_W : ascp_pkg::NUM_W;

  ascp_pkg::state_t state;
  ascp_pkg::state_t state_next;

  // Frame state.
  logic [7:0]       prefix [5];
  logic [2:0]       frame_len;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] dcount;
  logic             verr;
  logic             prev_cr;
  logic [9:0]       setpoint_reg;
  logic [15:0]      actual_q;

  // Text pointer.
  logic [ascp_pkg::PTR_W-1:0] ptr;
  logic [ascp_pkg::PTR_W-1:0] ptr_end;

  // Conversion unit interface.
  ascp_pkg::dig_req_t dig_req;
  ascp_pkg::dig_rsp_t dig_rsp;
  logic [ascp_pkg::NUM_W-1:0] dig_value;

  // Per-byte signals.
  logic       item_acc;
  logic       is_cr;
  logic       is_lf;
  logic       is_digit;
  logic       end_frame;
  logic       byte_val;
  logic       cr_err;
  logic       room;
  logic [2:0] pos;

  // Decode signals.
  logic [CMP_W-1:0] acc_ext;
  logic [39:0]      word5;
  logic             is_set;
  logic             len5;
  logic             dec_num;
  logic [9:0]       sp_dec;
  logic [ascp_pkg::PTR_W-1:0] txt_first;
  logic [ascp_pkg::PTR_W-1:0] txt_last;

  // Output loading.
  logic       out_free;
  logic       load_out;
  logic [7:0] load_byte;
  logic       load_last;

  ascp_digit_unit u_digit (
    .clk   (clk),
    .rst   (rst),
    .req   (dig_req),
    .value (dig_value),
    .rsp   (dig_rsp)
  );

  // Byte classification.
  assign item_ready = (state == ascp_pkg::ST_IDLE);
  assign item_acc   = item_valid && item_ready;
  assign pos        = frame_len;
  assign is_cr      = (item.rx_byte == ascp_pkg::CH_CR);
  assign is_lf      = (item.rx_byte == ascp_pkg::CH_LF);
  assign is_digit   = (item.rx_byte >= ascp_pkg::CH_ZERO) &&
                      (item.rx_byte <= ascp_pkg::CH_NINE);
  assign end_frame  = item_acc && prev_cr && is_lf;
  assign cr_err     = prev_cr && (pos >= 3'd5);
  assign byte_val   = !is_cr && (pos >= 3'd4);
  assign room       = (dcount < CNT_W'(MAX_DIGITS));
  assign out_free   = !reply_valid || reply_ready;

  // Command decode from the collected frame.
  always_comb begin
    acc_ext   = CMP_W'(acc);
    word5     = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4]};
    is_set    = (frame_len >= 3'd4) && (word5[39:8] == ascp_pkg::TXT_SET);
    len5      = (frame_len == 3'd5);
    dec_num   = 1'b0;
    dig_value = '0;
    sp_dec    = setpoint_reg;
    txt_first = ascp_pkg::MSG_UNK_FIRST;
    txt_last  = ascp_pkg::MSG_UNK_LAST;
    if (is_set) begin
      if (verr || dcount == '0) begin
        txt_first = ascp_pkg::MSG_UNK_FIRST;
      end else if (acc_ext <= CMP_W'(ascp_pkg::SP_MAX)) begin
        sp_dec    = acc_ext[9:0];
        dec_num   = 1'b1;
        dig_value = acc_ext[ascp_pkg::NUM_W-1:0];
      end else if (acc_ext < CMP_W'(ascp_pkg::VAL_LIMIT)) begin
        txt_first = ascp_pkg::MSG_RANG_FIRST;
        txt_last  = ascp_pkg::MSG_RANG_LAST;
      end
    end else if (len5 && word5 == ascp_pkg::TXT_INC) begin
      sp_dec    = (setpoint_reg >= 10'd1022) ? 10'd1023 : setpoint_reg + 10'd2;
      txt_first = ascp_pkg::MSG_MM_FIRST;
      txt_last  = ascp_pkg::MSG_MM_LAST;
    end else if (len5 && word5 == ascp_pkg::TXT_DEC) begin
      sp_dec    = (setpoint_reg <= 10'd2) ? 10'd0 : setpoint_reg - 10'd2;
      txt_first = ascp_pkg::MSG_MM_FIRST;
      txt_last  = ascp_pkg::MSG_MM_LAST;
    end else if (len5 && word5 == ascp_pkg::TXT_REQ) begin
      dec_num   = 1'b1;
      dig_value = {6'd0, setpoint_reg};
    end else if (len5 && word5 == ascp_pkg::TXT_MON) begin
      dec_num   = 1'b1;
      dig_value = actual_q;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ascp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_next    = state;
    dig_req.start = 1'b0;
    dig_req.take  = 1'b0;
    load_out      = 1'b0;
    load_byte     = ascp_pkg::MSG_ROM[ptr];
    load_last     = 1'b0;
    unique case (state)
      ascp_pkg::ST_IDLE: begin
        if (end_frame) begin
          state_next = ascp_pkg::ST_DECODE;
        end
      end
      ascp_pkg::ST_DECODE: begin
        if (dec_num) begin
          dig_req.start = 1'b1;
          state_next    = ascp_pkg::ST_NUM;
        end else begin
          state_next = ascp_pkg::ST_TEXT;
        end
      end
      ascp_pkg::ST_TEXT: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_last = (ptr == ptr_end);
          if (ptr == ptr_end) begin
            state_next = ascp_pkg::ST_IDLE;
          end
        end
      end
      ascp_pkg::ST_NUM: begin
        load_byte = ascp_pkg::CH_ZERO | {4'd0, dig_rsp.digit};
        if (dig_rsp.valid && out_free) begin
          load_out     = 1'b1;
          dig_req.take = 1'b1;
          if (dig_rsp.last_digit) begin
            state_next = ascp_pkg::ST_TEXT;
          end
        end
      end
      default: begin
        state_next = ascp_pkg::ST_IDLE;
      end
    endcase
  end

  // Frame collection and setpoint.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len    <= 3'd0;
      acc          <= '0;
      dcount       <= '0;
      verr         <= 1'b0;
      prev_cr      <= 1'b0;
      setpoint_reg <= 10'd0;
    end else if (state == ascp_pkg::ST_DECODE) begin
      setpoint_reg <= sp_dec;
      frame_len    <= 3'd0;
      acc          <= '0;
      dcount       <= '0;
      verr         <= 1'b0;
      prev_cr      <= 1'b0;
    end else if (item_acc) begin
      frame_len <= (pos == 3'd7) ? 3'd7 : pos + 3'd1;
      if (end_frame) begin
        prev_cr <= 1'b0;
      end else begin
        prev_cr <= is_cr;
        if (cr_err || (byte_val && !(is_digit && room))) begin
          verr <= 1'b1;
        end
        if (byte_val && is_digit && room) begin
          acc    <= ACC_W'({acc, 3'b000}) + ACC_W'({acc, 1'b0}) +
                    ACC_W'(item.rx_byte[3:0]);
          dcount <= dcount + 1'b1;
        end
      end
    end
  end

  // Frame prefix and the value captured with the closing byte.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      if (pos < 3'd5) begin
        prefix[pos] <= item.rx_byte;
      end
      actual_q <= item.actual_value;
    end
  end

  // Text pointer: set at decode, restarted for the CR LF after a number.
  always_ff @(posedge clk) begin
    if (state == ascp_pkg::ST_DECODE) begin
      ptr     <= txt_first;
      ptr_end <= txt_last;
    end else if (state == ascp_pkg::ST_NUM && dig_req.take && dig_rsp.last_digit) begin
      ptr     <= ascp_pkg::MSG_CRLF_FIRST;
      ptr_end <= ascp_pkg::MSG_CRLF_LAST;
    end else if (state == ascp_pkg::ST_TEXT && load_out) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (load_out) begin
      reply_valid <= 1'b1;
    end else if (reply_ready) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      reply.response_byte <= load_byte;
      reply.last_of_reply <= load_last;
      reply.setpoint      <= setpoint_reg;
    end
  end

endmodule

// ===== design/ascp_checker.sv =====
// ----------------------------------------------------------------------------
// ASCP port checker
// Watches the top-level ports of the command parser over time and is bound
// to every instance of it.
// ----------------------------------------------------------------------------
`include "ascii_setpoint_command_parser_macros.svh"

module ascp_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input ascp_pkg::item_t  item,
  input logic             reply_valid,
  input logic             reply_ready,
  input ascp_pkg::reply_t reply
);

  // Reset empties the output register.
  `ASCP_ASSERT_RST(a_reset_clears_reply, !reply_valid, "reply valid right after reset")

  // A stalled reply transaction keeps its byte.
  `ASCP_ASSERT_NXT(a_reply_holds, reply_valid && !reply_ready, reply_valid && $stable(reply), "stalled reply changed")

  // No new byte is taken while a reply is still being produced.
  `ASCP_ASSERT_IMP(a_busy_mid_reply, reply_valid && !reply.last_of_reply, !item_ready, "input taken in the middle of a reply")

  // Only a closing LF can start a reply.
  `ASCP_ASSERT_NXT(a_no_reply_mid_frame, item_valid && item_ready && !reply_valid && item.rx_byte != ascp_pkg::CH_LF, !reply_valid, "reply without a frame end")

endmodule

bind ascii_setpoint_command_parser ascp_checker u_ascp_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ASCII setpoint command parser testbench
// Sends command frames one byte per transaction and checks every reply byte,
// including its last-byte flag and setpoint, against a shadow parser kept in
// the testbench. A short table of directed frames comes first, followed by
// random frames, broken frames and noise, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  // Kinds of random frame.
  typedef enum int unsigned {
    FR_SET,
    FR_INC,
    FR_DEC,
    FR_REQ,
    FR_MON,
    FR_BROKEN,
    FR_NOISE
  } frame_kind_t;

  localparam int unsigned RANDOM_BYTES = 330;
  localparam int unsigned REPORT_LIMIT = 40;
  localparam string REPLY_UNKNOWN = "UNKNOWN COMMAND";
  localparam string REPLY_RANGE   = "OUT OF RANG";
  localparam string REPLY_STEP    = "mm";

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  ascp_pkg::item_t   item;
  logic              reply_valid;
  logic              reply_ready;
  ascp_pkg::reply_t  reply;

  string   crlf = "\015\012";

  // Shadow parser state.
  logic [9:0]  shadow_setpoint = '0;
  logic [7:0]  frame_bytes [5];
  int unsigned frame_len = 0;
  int unsigned value_acc = 0;
  int unsigned value_digits = 0;
  bit          value_bad = 1'b0;
  bit          cr_held = 1'b0;

  // Reply bytes still owed by the block, oldest first.
  ascp_pkg::reply_t pending_replies [$];

  // Directed frame table: text, measured value, and reply text when obvious.
  string       row_text [$];
  int unsigned row_actual [$];
  string       row_want [$];

  int unsigned bytes_sent = 0;
  int unsigned frames_closed = 0;
  int unsigned replies_checked = 0;
  int unsigned mismatch_count = 0;
  bit          sender_gaps_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned calm_left = 0;

  ascii_setpoint_command_parser dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .reply_valid (reply_valid),
    .reply_ready (reply_ready),
    .reply       (reply)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // True when the frame so far begins with the low n bytes of word, highest first.
  function automatic bit frame_starts(logic [39:0] word, int unsigned n);
    int unsigned i;
    if (frame_len < n) return 1'b0;
    for (i = 0; i < n; i++) begin
      if (frame_bytes[i] != word[8*(n-1-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One byte of the value text after "SET ".
  function automatic void take_value_char(logic [7:0] b);
    if (b < ascp_pkg::CH_ZERO || b > ascp_pkg::CH_NINE ||
        value_digits >= ascp_pkg::MAX_DIGITS_DEF) begin
      value_bad = 1'b1;
    end else begin
      value_acc = value_acc * 10 + int'(b - ascp_pkg::CH_ZERO);
      value_digits++;
    end
  endfunction

  // Decode a closed frame, update the setpoint and give the reply body.
  function automatic string finish_frame(logic [15:0] actual);
    string body;
    if (frame_starts({8'h00, ascp_pkg::TXT_SET}, 4)) begin
      if (value_bad || value_digits == 0) begin
        body = REPLY_UNKNOWN;
      end else if (value_acc <= ascp_pkg::SP_MAX) begin
        shadow_setpoint = 10'(value_acc);
        body = $sformatf("%0d", value_acc);
      end else if (value_acc < ascp_pkg::VAL_LIMIT) begin
        body = REPLY_RANGE;
      end else begin
        body = REPLY_UNKNOWN;
      end
    end else if (frame_len == 5 && frame_starts(ascp_pkg::TXT_INC, 5)) begin
      if (shadow_setpoint > 10'(ascp_pkg::SP_MAX - 2)) shadow_setpoint = 10'(ascp_pkg::SP_MAX);
      else shadow_setpoint = shadow_setpoint + 10'd2;
      body = REPLY_STEP;
    end else if (frame_len == 5 && frame_starts(ascp_pkg::TXT_DEC, 5)) begin
      if (shadow_setpoint <= 10'd2) shadow_setpoint = '0;
      else shadow_setpoint = shadow_setpoint - 10'd2;
      body = REPLY_STEP;
    end else if (frame_len == 5 && frame_starts(ascp_pkg::TXT_REQ, 5)) begin
      body = $sformatf("%0d", shadow_setpoint);
    end else if (frame_len == 5 && frame_starts(ascp_pkg::TXT_MON, 5)) begin
      body = $sformatf("%0d", actual);
    end else begin
      body = REPLY_UNKNOWN;
    end
    frame_len = 0;
    value_acc = 0;
    value_digits = 0;
    value_bad = 1'b0;
    cr_held = 1'b0;
    return body;
  endfunction

  // Shadow parser step for one received byte; empty unless the frame closed.
  function automatic string take_rx_byte(logic [7:0] b, logic [15:0] actual);
    int unsigned pos;
    pos = frame_len;
    if (pos < 5) frame_bytes[pos] = b;
    frame_len = (pos < 7) ? pos + 1 : 7;
    // A held CR either closes the frame or becomes an ordinary byte.
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == ascp_pkg::CH_LF) return finish_frame(actual);
      if (pos >= 5) take_value_char(ascp_pkg::CH_CR);
    end
    if (b == ascp_pkg::CH_CR) cr_held = 1'b1;
    else if (pos >= 4) take_value_char(b);
    return "";
  endfunction

  // Queue the reply bytes of one frame; every reply ends in CR LF.
  function automatic void queue_reply_text(string body);
    string            full;
    ascp_pkg::reply_t r;
    int               i;
    full = {body, crlf};
    for (i = 0; i < full.len(); i++) begin
      r.response_byte = full[i];
      r.last_of_reply = (i == full.len() - 1);
      r.setpoint      = shadow_setpoint;
      pending_replies.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // Compare one reply transaction with the oldest pending reply byte.
  task automatic check_reply(ascp_pkg::reply_t got);
    ascp_pkg::reply_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch($sformatf("reply byte 0x%02h with nothing pending",
                                got.response_byte));
    end else begin
      want = pending_replies.pop_front();
      replies_checked++;
      if (got.response_byte !== want.response_byte)
        report_mismatch($sformatf("response_byte 0x%02h, expected 0x%02h",
                                  got.response_byte, want.response_byte));
      if (got.last_of_reply !== want.last_of_reply)
        report_mismatch($sformatf("last_of_reply %0b, expected %0b",
                                  got.last_of_reply, want.last_of_reply));
      if (got.setpoint !== want.setpoint)
        report_mismatch($sformatf("setpoint %0d, expected %0d", got.setpoint, want.setpoint));
    end
  endtask

  // Reply channel monitor.
  always @(posedge clk) begin
    if (!rst && reply_valid && reply_ready) check_reply(reply);
  end

  // Reply channel back-pressure, with occasional calm stretches.
  initial begin
    reply_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        reply_ready = 1'b0;
        hold_left--;
      end else begin
        reply_ready = 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(50, 200);
        else hold_left = pick_gap();
      end
    end
  end

  // Send one byte as one transaction and feed the shadow parser on acceptance.
  task automatic send_byte(logic [7:0] b, logic [15:0] actual, string want);
    int unsigned gap;
    string       body;
    gap = sender_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid        = 1'b1;
    item.rx_byte      = b;
    item.actual_value = actual;
    do @(posedge clk); while (!item_ready);
    bytes_sent++;
    body = take_rx_byte(b, actual);
    if (body.len() > 0) begin
      frames_closed++;
      queue_reply_text((want.len() > 0) ? want : body);
    end
  endtask

  // Send a whole text; the measured value rides on the last byte.
  task automatic send_frame(string text, logic [15:0] actual, string want);
    int i;
    for (i = 0; i < text.len(); i++) begin
      send_byte(text[i],
                (i == text.len() - 1) ? actual : 16'($urandom_range(0, 65535)),
                want);
    end
  endtask

  // Hold off the sender until every pending reply byte has arrived.
  task automatic drain_replies();
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(string text, int unsigned actual, string want);
    row_text.push_back(text);
    row_actual.push_back(actual);
    row_want.push_back(want);
  endfunction

  // Value text for a random SET frame: mostly in range, sometimes not.
  function automatic string random_value_text();
    int unsigned r;
    int unsigned v;
    string       odd;
    r = $urandom_range(0, 99);
    odd = " ";
    if (r < 15) begin
      v = ($urandom_range(0, 1)) ? ascp_pkg::SP_MAX : $urandom_range(0, 3);
      return $sformatf("%0d", v);
    end
    if (r < 55) return $sformatf("%0d", $urandom_range(0, ascp_pkg::SP_MAX));
    if (r < 62) return $sformatf("%04d", $urandom_range(0, 999));
    if (r < 75) begin
      return $sformatf("%0d", $urandom_range(ascp_pkg::SP_MAX + 1,
                                             ascp_pkg::VAL_LIMIT - 1));
    end
    if (r < 80) return "9999";
    if (r < 86) return $sformatf("%05d", $urandom_range(0, 99999));
    if (r < 91) return "";
    // A stray byte inside the digits, often a lone CR.
    odd[0] = ($urandom_range(0, 1)) ? ascp_pkg::CH_CR : 8'($urandom_range(1, 255));
    return {$sformatf("%0d", $urandom_range(0, 99)), odd,
            $sformatf("%0d", $urandom_range(0, 9))};
  endfunction

  // Main stimulus.
  initial begin
    int unsigned  i;
    int unsigned  n;
    int unsigned  r;
    frame_kind_t  kind;
    string        text;
    string        extra;
    logic [15:0]  actual;

    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames: extremes, every command, and the odd cases.
    add_row({"REQ", crlf}, 0, "0");
    add_row({"SET 1023", crlf}, 0, "1023");
    add_row({"INC", crlf}, 0, REPLY_STEP);
    add_row({"SET 0001", crlf}, 0, "");
    add_row({"DEC", crlf}, 0, REPLY_STEP);
    add_row({"MON", crlf}, 65535, "65535");
    add_row({"SET 1024", crlf}, 0, REPLY_RANGE);
    add_row({"SET 9999", crlf}, 0, REPLY_UNKNOWN);
    add_row({"SET 12345", crlf}, 0, REPLY_UNKNOWN);
    add_row({"SET ", crlf}, 0, REPLY_UNKNOWN);
    add_row({"SET 1", "\015", "2", crlf}, 0, REPLY_UNKNOWN);
    add_row({"IN", crlf}, 0, REPLY_UNKNOWN);
    add_row(crlf, 0, REPLY_UNKNOWN);
    for (i = 0; i < row_text.size(); i++) begin
      if (i == 5) drain_replies();
      send_frame(row_text[i], 16'(row_actual[i]), row_want[i]);
    end

    // Random frames until the byte budget is spent.
    while (bytes_sent < row_text.size() + RANDOM_BYTES) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) drain_replies();
      r = $urandom_range(0, 99);
      if (r < 35) kind = FR_SET;
      else if (r < 45) kind = FR_INC;
      else if (r < 55) kind = FR_DEC;
      else if (r < 65) kind = FR_REQ;
      else if (r < 75) kind = FR_MON;
      else if (r < 92) kind = FR_BROKEN;
      else kind = FR_NOISE;
      r = $urandom_range(0, 3);
      actual = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      case (kind)
        FR_SET: send_frame({"SET ", random_value_text(), crlf}, actual, "");
        FR_INC: send_frame({"INC", crlf}, actual, "");
        FR_DEC: send_frame({"DEC", crlf}, actual, "");
        FR_REQ: send_frame({"REQ", crlf}, actual, "");
        FR_MON: send_frame({"MON", crlf}, actual, "");
        FR_BROKEN: begin
          case ($urandom_range(0, 3))
            0: text = "INC";
            1: text = "DEC";
            2: text = "REQ";
            default: text = "MON";
          endcase
          if ($urandom_range(0, 1)) begin
            // One corrupted command byte.
            text[$urandom_range(0, 2)] = 8'($urandom_range(1, 255));
            text = {text, crlf};
          end else begin
            // Command with trailing junk, or cut short.
            extra = "";
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++) extra = {extra, "X"};
            for (i = 0; i < n; i++) extra[i] = 8'($urandom_range(33, 126));
            if (n == 0) text = {text.substr(0, $urandom_range(0, 1)), crlf};
            else text = {text, extra, crlf};
          end
          send_frame(text, actual, "");
        end
        default: begin
          // Raw noise; it merges into the next frame.
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) begin
            send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), "");
          end
        end
      endcase
    end

    // Let the last replies drain, then allow for stray output.
    @(negedge clk);
    item_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d bytes closing %0d frames, checked %0d reply bytes, %0d mismatches",
             bytes_sent, frames_closed, replies_checked, mismatch_count);
    $display("covered SET in and out of range, INC/DEC saturation, REQ, MON and broken frames");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
